@@ hdl/bdda_pkg.sv @@
package bdda_pkg;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
    localparam logic [1:0] STATUS_NO_DAYS  = 2'd2;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [2:0] WEEKDAY_SAT = 3'd6;
    localparam logic [6:0] MASK_ALL = 7'h7f;
    localparam logic [6:0] MASK_RESET = 7'd96;

    typedef struct packed {
        logic [13:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [11:0] business_days;
    } item_t;

    typedef struct packed {
        logic [13:0] end_year;
        logic [3:0]  end_month;
        logic [4:0]  end_day;
        logic [2:0]  end_weekday;
        logic [1:0]  status;
    } result_t;

    // classified item handed from the front to the walker
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [11:0] count;
        logic [1:0]  status;
        logic [6:0]  year_mod100;
        logic [8:0]  year_mod400;
    } job_t;

    function automatic logic leap_year(input logic [1:0] y_low, input logic [6:0] mod100,
                                       input logic [8:0] mod400);
        leap_year = ((y_low == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
    endfunction

    // length of month, zero for a month code that means nothing
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    month_days = 5'd30;
            MONTH_FEB:                                  month_days = leap ? 5'd29 : 5'd28;
            default:                                    month_days = 5'd0;
        endcase
    endfunction

endpackage

@@ hdl/bdda_front.sv @@
module bdda_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  bdda_pkg::item_t item,
    input  logic [6:0]      weekend_mask,
    output logic            job_valid,
    input  logic            job_full,
    output bdda_pkg::job_t  job
);

    typedef enum logic [3:0]
    {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_SUM  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;

    bdda_pkg::item_t item_reg;
    logic [13:0] yy_reg;
    logic [3:0]  mm_reg;
    logic [7:0]  qy_reg;
    logic [7:0]  qyy_reg;
    logic [14:0] sum_reg;
    logic [6:0]  mod100_reg;
    logic [8:0]  mod400_reg;
    logic        bad_reg;
    logic        no_days_reg;

    logic        march_split;
    logic [13:0] yy_next;
    logic [3:0]  mm_next;
    logic [26:0] prod_y;
    logic [26:0] prod_yy;
    logic [13:0] rem100;
    logic [13:0] rem400;
    logic        leap;
    logic [4:0]  mdays;
    logic        bad;
    logic [4:0]  month_term;
    logic [14:0] sum_next;
    logic [5:0]  fold1;
    logic [3:0]  fold2;
    logic [2:0]  weekday;

    // (31 * shifted month) / 12
    function automatic logic [4:0] month_offset(input logic [3:0] mm);
        case (mm)
            4'd1:    month_offset = 5'd2;
            4'd2:    month_offset = 5'd5;
            4'd3:    month_offset = 5'd7;
            4'd4:    month_offset = 5'd10;
            4'd5:    month_offset = 5'd12;
            4'd6:    month_offset = 5'd15;
            4'd7:    month_offset = 5'd18;
            4'd8:    month_offset = 5'd20;
            4'd9:    month_offset = 5'd23;
            4'd10:   month_offset = 5'd25;
            4'd11:   month_offset = 5'd28;
            4'd12:   month_offset = 5'd31;
            default: month_offset = 5'd0;
        endcase
    endfunction

    assign full = (state_reg != F_IDLE);

    // year split at march
    assign march_split = (item.start_month < 4'd3);
    assign yy_next = item.start_year - {13'd0, march_split};
    assign mm_next = march_split ? item.start_month + 4'd10 : item.start_month - 4'd2;

    // divide by 100 through reciprocal, exact for 14-bit values
    assign prod_y  = {13'd0, item_reg.start_year} * 27'd5243;
    assign prod_yy = {13'd0, yy_reg} * 27'd5243;

    assign rem100 = item_reg.start_year - 14'({6'd0, qy_reg} * 14'd100);
    assign rem400 = item_reg.start_year - 14'({8'd0, qy_reg[7:2]} * 14'd400);
    assign leap = bdda_pkg::leap_year(item_reg.start_year[1:0], rem100[6:0], rem400[8:0]);
    assign mdays = bdda_pkg::month_days(item_reg.start_month, leap);
    assign bad = (item_reg.start_year < 14'd1) || (item_reg.start_year > 14'd9999)
                 || (mdays == 5'd0) || (item_reg.start_day < 5'd1)
                 || (item_reg.start_day > mdays);
    assign month_term = month_offset(mm_reg);
    assign sum_next = {10'd0, item_reg.start_day} + {1'd0, yy_reg} + {3'd0, yy_reg[13:2]}
                      - {7'd0, qyy_reg} + {9'd0, qyy_reg[7:2]} + {10'd0, month_term};

    // mod 7 by folding octal digits
    assign fold1 = {3'd0, sum_reg[2:0]} + {3'd0, sum_reg[5:3]} + {3'd0, sum_reg[8:6]}
                   + {3'd0, sum_reg[11:9]} + {3'd0, sum_reg[14:12]};
    assign fold2 = {1'd0, fold1[2:0]} + {1'd0, fold1[5:3]};
    assign weekday = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    always_comb
    begin
        job.year        = item_reg.start_year;
        job.month       = item_reg.start_month;
        job.day         = item_reg.start_day;
        job.year_mod100 = mod100_reg;
        job.year_mod400 = mod400_reg;
        if (bad_reg)
        begin
            job.weekday = 3'd0;
            job.count   = 12'd0;
            job.status  = bdda_pkg::STATUS_BAD_DATE;
        end
        else if (no_days_reg)
        begin
            job.weekday = weekday;
            job.count   = 12'd0;
            job.status  = bdda_pkg::STATUS_NO_DAYS;
        end
        else
        begin
            job.weekday = weekday;
            job.count   = item_reg.business_days;
            job.status  = bdda_pkg::STATUS_OK;
        end
    end

    assign job_valid = (state_reg == F_PUSH);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (push) state_next = F_MUL;
            F_MUL:   state_next = F_SUM;
            F_SUM:   state_next = F_PUSH;
            F_PUSH:  if (!job_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            item_reg <= item;
            yy_reg   <= yy_next;
            mm_reg   <= mm_next;
        end
        if (state_reg == F_MUL)
        begin
            qy_reg  <= prod_y[26:19];
            qyy_reg <= prod_yy[26:19];
        end
        if (state_reg == F_SUM)
        begin
            sum_reg     <= sum_next;
            mod100_reg  <= rem100[6:0];
            mod400_reg  <= rem400[8:0];
            bad_reg     <= bad;
            no_days_reg <= (item_reg.business_days != 12'd0)
                           && (weekend_mask == bdda_pkg::MASK_ALL);
        end
    end

endmodule

@@ hdl/bdda_queue.sv @@
module bdda_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bdda_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output bdda_pkg::job_t pop_data,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    bdda_pkg::job_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ hdl/bdda_walk.sv @@
module bdda_walk
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    output logic               job_pop,
    input  bdda_pkg::job_t     job,
    input  logic [6:0]         weekend_mask,
    output logic               empty,
    input  logic               pop,
    output bdda_pkg::result_t  result
);

    typedef enum logic [1:0]
    {
        B_IDLE = 2'b01,
        B_WALK = 2'b10
    } walk_state_t;

    walk_state_t state_reg, state_next;

    logic [13:0] walk_year_reg;
    logic [3:0]  walk_month_reg;
    logic [4:0]  walk_day_reg;
    logic [2:0]  walk_weekday_reg;
    logic [11:0] days_left_reg;
    logic [1:0]  status_reg;
    logic [6:0]  mod100_reg;
    logic [8:0]  mod400_reg;
    bdda_pkg::result_t result_reg;
    logic        result_valid_reg;

    logic leap;
    logic month_end;
    logic finish;
    logic step;

    assign leap = bdda_pkg::leap_year(walk_year_reg[1:0], mod100_reg, mod400_reg);
    assign month_end = (walk_day_reg == bdda_pkg::month_days(walk_month_reg, leap));

    assign job_pop = (state_reg == B_IDLE) && !job_empty;
    // result register frees up in the same cycle it is popped
    assign finish  = (state_reg == B_WALK) && (days_left_reg == 12'd0)
                     && (!result_valid_reg || pop);
    assign step    = (state_reg == B_WALK) && (days_left_reg != 12'd0);

    assign empty  = !result_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!job_empty) state_next = B_WALK;
            B_WALK:  if (finish) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
                result_valid_reg <= 1'b1;
            else if (pop)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            walk_year_reg    <= job.year;
            walk_month_reg   <= job.month;
            walk_day_reg     <= job.day;
            walk_weekday_reg <= job.weekday;
            days_left_reg    <= job.count;
            status_reg       <= job.status;
            mod100_reg       <= job.year_mod100;
            mod400_reg       <= job.year_mod400;
        end
        else if (step)
        begin
            if (!weekend_mask[walk_weekday_reg])
                days_left_reg <= days_left_reg - 12'd1;
            if (month_end)
            begin
                walk_day_reg <= 5'd1;
                if (walk_month_reg == bdda_pkg::MONTH_DEC)
                begin
                    walk_month_reg <= bdda_pkg::MONTH_JAN;
                    walk_year_reg  <= walk_year_reg + 14'd1;
                    mod100_reg     <= (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_reg     <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                end
                else
                begin
                    walk_month_reg <= walk_month_reg + 4'd1;
                end
            end
            else
            begin
                walk_day_reg <= walk_day_reg + 5'd1;
            end
            walk_weekday_reg <= (walk_weekday_reg == bdda_pkg::WEEKDAY_SAT)
                                ? 3'd0 : walk_weekday_reg + 3'd1;
        end
        if (finish)
        begin
            result_reg.end_year    <= walk_year_reg;
            result_reg.end_month   <= walk_month_reg;
            result_reg.end_day     <= walk_day_reg;
            result_reg.end_weekday <= walk_weekday_reg;
            result_reg.status      <= status_reg;
        end
    end

endmodule

@@ hdl/business_day_date_advance.sv @@
// business-day date advance over the gregorian calendar
//
// input channel: item (start date and business-day count) is taken on a
// beat where push is high and full is low. result channel: the oldest
// result sits on result while empty is low and leaves on a beat where pop
// is high. config channel: cfg_data is the 7-bit weekend mask (bit n marks
// weekday n, 0 sunday), written on a beat where cfg_valid and cfg_ready are
// high; cfg_ready is always high. write it only while the block is idle.
//
// in the front an item is captured, divided by 100 through the reciprocal,
// summed to a weekday and folded mod 7 as it is pushed into the queue; the
// walker then takes it from the queue, steps one calendar day a cycle and
// loads the result register when the count runs out. the front classifies
// the next item while the walker works, so on long walks the walker, not
// the front, sets the pace.
//
// reset empties the queue and the result register and sets the weekend
// mask to friday and saturday. while pop stays low the finished result
// holds, the walker waits with its next date, and full rises as the queue
// and the front fill up.
module business_day_date_advance
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  bdda_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output bdda_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [6:0]        cfg_data
);

    logic [6:0] weekend_mask_reg;
    logic           job_valid;
    logic           job_full;
    logic           job_empty;
    logic           job_pop;
    bdda_pkg::job_t front_job;
    bdda_pkg::job_t queue_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weekend_mask_reg <= bdda_pkg::MASK_RESET;
        else if (cfg_valid && cfg_ready)
            weekend_mask_reg <= cfg_data;
    end

    bdda_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .weekend_mask (weekend_mask_reg),
        .job_valid    (job_valid),
        .job_full     (job_full),
        .job          (front_job)
    );

    bdda_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (front_job),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (queue_job),
        .empty     (job_empty)
    );

    bdda_walk u_walk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_empty    (job_empty),
        .job_pop      (job_pop),
        .job          (queue_job),
        .weekend_mask (weekend_mask_reg),
        .empty        (empty),
        .pop          (pop),
        .result       (result)
    );

endmodule

@@ test/tb_business_day_date_advance.sv @@
module tb_business_day_date_advance;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASES      = 4;
    localparam int PER_PHASE   = 20;
    localparam int SETTLE_GAP  = 20;

    typedef struct packed {
        logic [6:0]        mask;
        bdda_pkg::item_t   it;
        logic              typed;
        bdda_pkg::result_t want;
    } plan_row_t;

    localparam int PLAN_ROWS = 23;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // reset mask, zero count and malformed dates
        '{bdda_pkg::MASK_RESET, '{14'd2024, 4'd1, 5'd1, 12'd0}, 1'b1,
          '{14'd2024, 4'd1, 5'd1, 3'd1, bdda_pkg::STATUS_OK}},
        '{bdda_pkg::MASK_RESET, '{14'd0, 4'd1, 5'd1, 12'd5}, 1'b1,
          '{14'd0, 4'd1, 5'd1, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        '{bdda_pkg::MASK_RESET, '{14'd10000, 4'd6, 5'd15, 12'd3}, 1'b1,
          '{14'd10000, 4'd6, 5'd15, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        '{bdda_pkg::MASK_RESET, '{14'd16383, 4'd15, 5'd31, 12'd4095}, 1'b1,
          '{14'd16383, 4'd15, 5'd31, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        '{bdda_pkg::MASK_RESET, '{14'd2023, 4'd0, 5'd10, 12'd1}, 1'b1,
          '{14'd2023, 4'd0, 5'd10, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        '{bdda_pkg::MASK_RESET, '{14'd2023, 4'd13, 5'd10, 12'd1}, 1'b1,
          '{14'd2023, 4'd13, 5'd10, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        '{bdda_pkg::MASK_RESET, '{14'd2023, 4'd4, 5'd0, 12'd1}, 1'b1,
          '{14'd2023, 4'd4, 5'd0, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        '{bdda_pkg::MASK_RESET, '{14'd2023, 4'd4, 5'd31, 12'd1}, 1'b1,
          '{14'd2023, 4'd4, 5'd31, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        '{bdda_pkg::MASK_RESET, '{14'd2023, 4'd2, 5'd29, 12'd1}, 1'b1,
          '{14'd2023, 4'd2, 5'd29, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        '{bdda_pkg::MASK_RESET, '{14'd1900, 4'd2, 5'd29, 12'd1}, 1'b1,
          '{14'd1900, 4'd2, 5'd29, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        // leap days, year rollover, far ends of the calendar
        '{bdda_pkg::MASK_RESET, '{14'd2000, 4'd2, 5'd29, 12'd7}, 1'b0, '0},
        '{bdda_pkg::MASK_RESET, '{14'd2024, 4'd2, 5'd29, 12'd1}, 1'b0, '0},
        '{bdda_pkg::MASK_RESET, '{14'd2023, 4'd12, 5'd31, 12'd10}, 1'b0, '0},
        '{bdda_pkg::MASK_RESET, '{14'd9999, 4'd12, 5'd31, 12'd4095}, 1'b0, '0},
        '{bdda_pkg::MASK_RESET, '{14'd1, 4'd1, 5'd1, 12'd4095}, 1'b0, '0},
        // every day a business day
        '{7'd0, '{14'd2023, 4'd12, 5'd31, 12'd1}, 1'b0, '0},
        '{7'd0, '{14'd1, 4'd1, 5'd1, 12'd1}, 1'b0, '0},
        '{7'd0, '{14'd2100, 4'd2, 5'd28, 12'd2}, 1'b0, '0},
        // no business day at all
        '{bdda_pkg::MASK_ALL, '{14'd2024, 4'd1, 5'd1, 12'd5}, 1'b1,
          '{14'd2024, 4'd1, 5'd1, 3'd1, bdda_pkg::STATUS_NO_DAYS}},
        '{bdda_pkg::MASK_ALL, '{14'd2024, 4'd1, 5'd1, 12'd0}, 1'b1,
          '{14'd2024, 4'd1, 5'd1, 3'd1, bdda_pkg::STATUS_OK}},
        '{bdda_pkg::MASK_ALL, '{14'd0, 4'd0, 5'd0, 12'd1}, 1'b1,
          '{14'd0, 4'd0, 5'd0, 3'd0, bdda_pkg::STATUS_BAD_DATE}},
        // saturday only: slowest walk, year runs past 9999
        '{7'h3f, '{14'd9999, 4'd12, 5'd31, 12'd4095}, 1'b0, '0},
        '{7'h3f, '{14'd2024, 4'd3, 5'd1, 12'd3}, 1'b0, '0}
    };

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    bdda_pkg::item_t   item;
    logic              empty;
    logic              pop;
    bdda_pkg::result_t result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [6:0]        cfg_data;

    bdda_pkg::result_t due_dates[$];
    bdda_pkg::result_t oldest_due;
    logic [6:0] mask_now;
    bit         calm;
    int         errors;
    int         cycles;
    int         n_items;
    int         n_bad;
    int         n_no_days;
    int         n_masks;
    int         max_year;
    int         pop_hold;

    business_day_date_advance i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned days_in(int unsigned m, int unsigned y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bdda_pkg::result_t advance_date(bdda_pkg::item_t it, logic [6:0] msk);
        int unsigned y, m, d, n, wd, a, yy, mm;
        bdda_pkg::result_t r;
        y  = it.start_year;
        m  = it.start_month;
        d  = it.start_day;
        n  = it.business_days;
        wd = 0;
        r.status = bdda_pkg::STATUS_OK;
        if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1 || d > days_in(m, y))
        begin
            r.status = bdda_pkg::STATUS_BAD_DATE;
        end
        else
        begin
            // march-based year so february sits at the end
            a  = (14 - m) / 12;
            yy = y - a;
            mm = m + 12 * a - 2;
            wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
            if (n != 0 && msk == bdda_pkg::MASK_ALL)
            begin
                r.status = bdda_pkg::STATUS_NO_DAYS;
            end
            else
            begin
                while (n != 0)
                begin
                    if (!msk[wd])
                        n--;
                    if (d == days_in(m, y))
                    begin
                        d = 1;
                        if (m == 12)
                        begin
                            m = 1;
                            y++;
                        end
                        else
                        begin
                            m++;
                        end
                    end
                    else
                    begin
                        d++;
                    end
                    wd = (wd + 1) % 7;
                end
            end
        end
        r.end_year    = 14'(y);
        r.end_month   = 4'(m);
        r.end_day     = 5'(d);
        r.end_weekday = 3'(wd);
        return r;
    endfunction

    function automatic int unsigned pick_year();
        case ($urandom_range(0, 4))
            0:       return 9999;
            1:       return 1;
            2:       return $urandom_range(1, 99) * 100;
            3:       return $urandom_range(1, 24) * 400;
            default: return $urandom_range(1, 9999);
        endcase
    endfunction

    function automatic bdda_pkg::item_t random_date_item(bit wide_count);
        bdda_pkg::item_t it;
        int unsigned y, m;
        y = pick_year();
        m = $urandom_range(1, 12);
        it.start_year  = 14'(y);
        it.start_month = 4'(m);
        it.start_day   = 5'($urandom_range(1, days_in(m, y)));
        case ($urandom_range(0, 9))
            0:
            begin
                // raw bits, mostly malformed
                it.start_year  = 14'($urandom);
                it.start_month = 4'($urandom);
                it.start_day   = 5'($urandom);
            end
            1: it.start_day = 5'(days_in(m, y));
            2:
            begin
                it.start_month = bdda_pkg::MONTH_FEB;
                it.start_day   = 5'd29;
            end
            3:
            begin
                it.start_month = bdda_pkg::MONTH_DEC;
                it.start_day   = 5'd31;
            end
            default: ;
        endcase
        it.business_days = wide_count ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(0, 40));
        return it;
    endfunction

    task automatic log_error(string msg);
        errors++;
        $display("[%0t] error %0d: %s", $realtime, errors, msg);
    endtask

    task automatic send_item(bdda_pkg::item_t it, bit typed, bdda_pkg::result_t want);
        bdda_pkg::result_t due;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 11))
            begin
                @(negedge clk);
                push <= 1'b0;
            end
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        due = typed ? want : advance_date(it, mask_now);
        due_dates.push_back(due);
        n_items++;
        if (due.status == bdda_pkg::STATUS_BAD_DATE)
            n_bad++;
        if (due.status == bdda_pkg::STATUS_NO_DAYS)
            n_no_days++;
        if (due.status == bdda_pkg::STATUS_OK && int'(due.end_year) > max_year)
            max_year = due.end_year;
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (due_dates.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mask(logic [6:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        mask_now = value;
        n_masks++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side: pop with random stall bursts
    initial
    begin
        pop      = 1'b0;
        pop_hold = 0;
        forever
        begin
            @(negedge clk);
            if (pop_hold > 0)
            begin
                pop <= 1'b0;
                pop_hold--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                pop      <= 1'b0;
                pop_hold = $urandom_range(1, 11) - 1;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (due_dates.size() == 0)
            begin
                log_error($sformatf("result %0d-%0d-%0d with nothing pending",
                                    result.end_year, result.end_month, result.end_day));
            end
            else
            begin
                oldest_due = due_dates.pop_front();
                if (result.end_year !== oldest_due.end_year)
                    log_error($sformatf("end_year got %0d want %0d",
                                        result.end_year, oldest_due.end_year));
                if (result.end_month !== oldest_due.end_month)
                    log_error($sformatf("end_month got %0d want %0d",
                                        result.end_month, oldest_due.end_month));
                if (result.end_day !== oldest_due.end_day)
                    log_error($sformatf("end_day got %0d want %0d",
                                        result.end_day, oldest_due.end_day));
                if (result.end_weekday !== oldest_due.end_weekday)
                    log_error($sformatf("end_weekday got %0d want %0d",
                                        result.end_weekday, oldest_due.end_weekday));
                if (result.status !== oldest_due.status)
                    log_error($sformatf("status got %0d want %0d",
                                        result.status, oldest_due.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     due_dates.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int wide_cnt;
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        mask_now  = bdda_pkg::MASK_RESET;
        calm      = 1'b0;
        errors    = 0;
        cycles    = 0;
        n_items   = 0;
        n_bad     = 0;
        n_no_days = 0;
        n_masks   = 0;
        max_year  = 0;
        wide_cnt  = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].mask != mask_now)
            begin
                settle();
                write_mask(PLAN[i].mask);
            end
            send_item(PLAN[i].it, PLAN[i].typed, PLAN[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_mask(7'($urandom_range(0, 126)));
            calm = (p == PHASES - 1);
            for (int k = 0; k < PER_PHASE; k++)
            begin
                // only every twelfth count spans the full range
                wide_cnt++;
                send_item(random_date_item(wide_cnt % 12 == 0), 1'b0, '0);
            end
        end

        settle();
        repeat (SETTLE_GAP) @(posedge clk);

        $display("ran %0d dates over %0d weekend masks: %0d malformed, %0d with no business day",
                 n_items, n_masks + 1, n_bad, n_no_days);
        $display("latest end year %0d, %0d cycles, %0d errors", max_year, cycles, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
